>>> src/lsfr_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lsfr_pkg
// Shared types, codes and helper functions of the LIN sensor frame receiver.
// ----------------------------------------------------------------------------
package lsfr_pkg;

	localparam int unsigned REQ_W   = 2;
	localparam int unsigned BYTE_W  = 8;
	localparam int unsigned ID_W    = 6;
	localparam int unsigned STALE_W = 18;
	localparam int unsigned TEMP_W  = 23;
	localparam int unsigned CFG_W   = 18;

	localparam logic [BYTE_W-1:0] SYNC_BYTE = 8'h55;
	localparam logic [ID_W-1:0]   ID_RESET = 6'd18;
	localparam logic [STALE_W-1:0] STALE_RESET = 18'd3000;

	typedef enum logic [REQ_W-1:0] {
		REQ_BYTE  = 2'd0,
		REQ_START = 2'd1,
		REQ_TICK  = 2'd2,
		REQ_READ  = 2'd3
	} req_t;

	typedef enum logic {
		CFG_FRAME_ID    = 1'b0,
		CFG_STALE_TICKS = 1'b1
	} cfg_idx_t;

	typedef struct packed {
		logic [BYTE_W-1:0]        tx_byte;
		logic                     tx_valid;
		logic signed [TEMP_W-1:0] temp_scaled;
		logic                     read_ok;
		logic                     frame_done;
		logic                     checksum_error;
		logic                     last;
	} res_t;

	localparam res_t RES_ZERO = '0;

	function automatic logic [BYTE_W-1:0] make_pid(input logic [ID_W-1:0] id);
		logic p0;
		logic p1;
		begin
			p0 = id[0] ^ id[1] ^ id[2] ^ id[4];
			p1 = ~(id[1] ^ id[3] ^ id[4] ^ id[5]);
			make_pid = {p1, p0, id};
		end
	endfunction

	function automatic logic [BYTE_W-1:0] add_carry(input logic [BYTE_W-1:0] a,
			input logic [BYTE_W-1:0] b);
		logic [BYTE_W:0] s;
		begin
			s = {1'b0, a} + {1'b0, b};
			add_carry = s[BYTE_W-1:0] + {{(BYTE_W-1){1'b0}}, s[BYTE_W]};
		end
	endfunction

	function automatic logic [BYTE_W-1:0] enhanced_sum(input logic [BYTE_W-1:0] pid,
			input logic [BYTE_W-1:0] d0, input logic [BYTE_W-1:0] d1);
		begin
			enhanced_sum = ~add_carry(add_carry(pid, d0), d1);
		end
	endfunction

endpackage

`default_nettype wire

>>> src/lin_sensor_frame_receiver_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lin_sensor_frame_receiver_unit
// LIN master frame side for one temperature node: header, response, reading.
// ----------------------------------------------------------------------------
// The first result of an item is held in the input register and then in the
// result queue before it is offered at m_tvalid.
// Throughput: one item per cycle while the result queue has room; a frame
// start needs both slots of the two-entry result queue, so it waits in the
// input register while an entry is left after the pop of that cycle.
// Reset clears control state and the reading; configuration returns to defaults.
module lin_sensor_frame_receiver_unit #(
	parameter int unsigned AGE_BITS = 18
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       cfg_we,
	input  wire logic                       cfg_addr,
	input  wire logic [lsfr_pkg::CFG_W-1:0] cfg_wdata,
	input  wire logic                       s_tvalid,
	output logic                            s_tready,
	input  wire logic [7:0]                 s_tdata,  // rx_byte[7:0]
	input  wire logic [1:0]                 s_tuser,  // req_type[1:0]
	output logic                            m_tvalid,
	input  wire logic                       m_tready,
	output logic [31:0]                     m_tdata,  // tx_byte[7:0], temp_scaled[30:8]
	output logic [3:0]                      m_tuser,  // tx_valid, read_ok, frame_done, checksum_error
	output logic                            m_tlast
);
	import lsfr_pkg::*;

	logic               v_s1;
	logic [REQ_W-1:0]   req_s1;
	logic [BYTE_W-1:0]  byte_s1;
	logic               go;
	logic               room;
	logic [1:0]         need;
	res_t               res0;
	res_t               res1;
	res_t               head;

	assign go = v_s1 && room;
	assign s_tready = !v_s1 || go;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (s_tready) begin
			v_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			req_s1 <= s_tuser;
			byte_s1 <= s_tdata;
		end
	end

	lsfr_core #(
		.AGE_BITS(AGE_BITS)
	) u_core (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_addr(cfg_addr),
		.cfg_wdata(cfg_wdata),
		.go(go),
		.req_type(req_s1),
		.rx_byte(byte_s1),
		.res0(res0),
		.res1(res1),
		.need(need)
	);

	lsfr_resq u_resq (
		.clk(clk),
		.arst_n(arst_n),
		.need(need),
		.push(go),
		.res0(res0),
		.res1(res1),
		.room(room),
		.head_valid(m_tvalid),
		.pop_ready(m_tready),
		.head(head)
	);

	assign m_tdata = {1'b0, head.temp_scaled, head.tx_byte};
	assign m_tuser = {head.checksum_error, head.frame_done, head.read_ok, head.tx_valid};
	assign m_tlast = head.last;

endmodule

`default_nettype wire

>>> src/lsfr_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lsfr_core
// Frame state, configuration registers and result generation for one item.
// ----------------------------------------------------------------------------
module lsfr_core #(
	parameter int unsigned AGE_BITS = 18
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_we,
	input  wire logic                          cfg_addr,
	input  wire logic [lsfr_pkg::CFG_W-1:0]    cfg_wdata,
	input  wire logic                          go,
	input  wire logic [lsfr_pkg::REQ_W-1:0]    req_type,
	input  wire logic [lsfr_pkg::BYTE_W-1:0]   rx_byte,
	output lsfr_pkg::res_t                     res0,
	output lsfr_pkg::res_t                     res1,
	output logic [1:0]                         need
);
	import lsfr_pkg::*;

	localparam int unsigned CMP_W = (AGE_BITS > STALE_W) ? AGE_BITS : STALE_W;

	logic [ID_W-1:0]         frame_id_q;
	logic [STALE_W-1:0]      stale_q;
	logic [1:0]              count_q;
	logic [BYTE_W-1:0]       d0_q;
	logic [BYTE_W-1:0]       d1_q;
	logic signed [TEMP_W-1:0] temp_q;
	logic                    have_q;
	logic [AGE_BITS-1:0]     age_q;

	logic [BYTE_W-1:0]       pid;
	logic                    sum_ok;
	logic                    fresh;
	logic signed [15:0]      raw;
	logic signed [23:0]      prod;
	req_t                    req;

	always_comb begin
		req = req_t'(req_type);
		pid = make_pid(frame_id_q);
		sum_ok = enhanced_sum(pid, d0_q, d1_q) == rx_byte;
		fresh = have_q && (CMP_W'(age_q) <= CMP_W'(stale_q));
		raw = $signed({d1_q, d0_q});
		prod = 24'(raw) * 24'sd100;
	end

	always_comb begin
		res0 = RES_ZERO;
		res1 = RES_ZERO;
		need = 2'd0;
		case (req)
			REQ_START: begin
				need = 2'd2;
				res0.tx_byte = SYNC_BYTE;
				res0.tx_valid = 1'b1;
				res1.tx_byte = pid;
				res1.tx_valid = 1'b1;
				res1.last = 1'b1;
			end
			REQ_READ: begin
				need = 2'd1;
				res0.read_ok = fresh;
				res0.temp_scaled = fresh ? temp_q : '0;
				res0.last = 1'b1;
			end
			REQ_BYTE: begin
				if (count_q == 2'd2) begin
					need = 2'd1;
					res0.frame_done = 1'b1;
					res0.checksum_error = !sum_ok;
					res0.last = 1'b1;
				end
			end
			default: begin
				need = 2'd0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_id_q <= ID_RESET;
			stale_q <= STALE_RESET;
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_addr))
				CFG_FRAME_ID: frame_id_q <= cfg_wdata[ID_W-1:0];
				CFG_STALE_TICKS: stale_q <= cfg_wdata[STALE_W-1:0];
				default: frame_id_q <= frame_id_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= 2'd0;
			temp_q <= '0;
			have_q <= 1'b0;
			age_q <= '0;
		end else if (go) begin
			case (req)
				REQ_START: count_q <= 2'd0;
				REQ_TICK: begin
					if (age_q != {AGE_BITS{1'b1}}) begin
						age_q <= age_q + AGE_BITS'(1);
					end
				end
				REQ_BYTE: begin
					if (count_q == 2'd2) begin
						count_q <= 2'd0;
						if (sum_ok) begin
							temp_q <= prod[TEMP_W-1:0];
							have_q <= 1'b1;
							age_q <= '0;
						end
					end else begin
						count_q <= count_q + 2'd1;
					end
				end
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (go && req == REQ_BYTE) begin
			if (count_q == 2'd0) begin
				d0_q <= rx_byte;
			end else if (count_q == 2'd1) begin
				d1_q <= rx_byte;
			end
		end
	end

endmodule

`default_nettype wire

>>> src/lsfr_resq.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lsfr_resq
// Two-entry result queue that takes up to two results per cycle when it has room.
// ----------------------------------------------------------------------------
module lsfr_resq (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic [1:0]      need,
	input  wire logic            push,
	input  wire lsfr_pkg::res_t  res0,
	input  wire lsfr_pkg::res_t  res1,
	output logic                 room,
	output logic                 head_valid,
	input  wire logic            pop_ready,
	output lsfr_pkg::res_t       head
);
	import lsfr_pkg::*;

	logic [1:0] count_q;
	res_t       e0_q;
	res_t       e1_q;
	logic       pop;
	logic [1:0] cnt_a;
	logic [1:0] free;
	logic [1:0] push_n;
	res_t       n0;
	res_t       n1;

	assign head_valid = count_q != 2'd0;
	assign head = e0_q;

	always_comb begin
		pop = head_valid && pop_ready;
		cnt_a = count_q - {1'b0, pop};
		free = 2'd2 - cnt_a;
		room = need <= free;
		push_n = push ? need : 2'd0;
		n0 = pop ? e1_q : e0_q;
		n1 = e1_q;
		case (cnt_a)
			2'd0: begin
				if (push_n != 2'd0) n0 = res0;
				if (push_n == 2'd2) n1 = res1;
			end
			2'd1: begin
				if (push_n != 2'd0) n1 = res0;
			end
			default: begin
				n1 = n1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= 2'd0;
		end else begin
			count_q <= cnt_a + push_n;
		end
	end

	always_ff @(posedge clk) begin
		e0_q <= n0;
		e1_q <= n1;
	end

endmodule

`default_nettype wire
